[hw/rtl/huffman_tree_bit_decoder_defines.svh]
// assertion macros for the code tree decoder
`ifndef HUFFMAN_TREE_BIT_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_BIT_DECODER_DEFINES_SVH

// generic clocked assertion with an active-low disable
`define HTD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// assertion on the block clock and reset
`define HTD_ASSERT(lbl, prop, msg) \
  `HTD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[hw/rtl/htd_pkg.sv]
`timescale 1ns / 1ps

package htd_pkg;

  localparam int unsigned HTD_NODE_COUNT   = 1024;
  localparam int unsigned HTD_MAX_CODE_LEN = 15;
  localparam int unsigned HTD_LEN_W        = 4;
  localparam int unsigned HTD_CODE_W       = 15;
  localparam int unsigned HTD_SYM_W        = 9;
  localparam int unsigned HTD_STATUS_W     = 3;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  typedef enum logic [HTD_STATUS_W-1:0] {
    ST_DECODED     = 3'd0,
    ST_CONSUMED    = 3'd1,
    ST_UNINDEXED   = 3'd2,
    ST_INSERTED    = 3'd3,
    ST_INSERT_FAIL = 3'd4
  } htd_status_e;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic dec_step;
    logic dec_chk;
    logic ins_rd;
    logic ins_look;
    logic ins_alloc;
    logic ins_fail;
    logic ins_ref;
    logic ins_load;
  } htd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic len_bad;
    logic dec_miss;
    logic look_final;
    logic look_hit;
    logic look_fits;
    logic alloc_last;
    logic res_busy;
  } htd_stat_t;

endpackage

[hw/rtl/htd_if.sv]
`timescale 1ns / 1ps

interface htd_in_if;
  import htd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [HTD_LEN_W-1:0]  code_length;
  logic [HTD_CODE_W-1:0] code_bits;
  logic [HTD_SYM_W-1:0]  symbol_value;
  logic                  stream_bit;

  modport source (
    output valid, kind, code_length, code_bits, symbol_value, stream_bit,
    input  ready
  );
  modport sink (
    input  valid, kind, code_length, code_bits, symbol_value, stream_bit,
    output ready
  );
endinterface

interface htd_out_if;
  import htd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [HTD_STATUS_W-1:0] status;
  logic [HTD_SYM_W-1:0]    symbol_out;

  modport source (
    output valid, status, symbol_out,
    input  ready
  );
  modport sink (
    input  valid, status, symbol_out,
    output ready
  );
endinterface

[hw/rtl/htd_ram.sv]
`timescale 1ns / 1ps

module htd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/htd_ctrl.sv]
`timescale 1ns / 1ps

module htd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_kind_i,
  output logic               in_ready_o,
  input  htd_pkg::htd_stat_t stat_i,
  output htd_pkg::htd_cmd_t  cmd_o
);
  import htd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_DEC_STEP  = 8'b0000_0010,
    S_DEC_CHK   = 8'b0000_0100,
    S_INS_RD    = 8'b0000_1000,
    S_INS_LOOK  = 8'b0001_0000,
    S_INS_ALLOC = 8'b0010_0000,
    S_INS_REF   = 8'b0100_0000,
    S_INS_LOAD  = 8'b1000_0000
  } htd_state_e;

  htd_state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && !stat_i.res_busy;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.take = 1'b1;
          state_d    = (in_kind_i == KIND_DECODE) ? S_DEC_STEP : S_INS_RD;
        end
      end
      S_DEC_STEP: begin
        cmd_o.dec_step = 1'b1;
        state_d        = stat_i.dec_miss ? S_IDLE : S_DEC_CHK;
      end
      S_DEC_CHK: begin
        cmd_o.dec_chk = 1'b1;
        state_d       = S_IDLE;
      end
      S_INS_RD: begin
        if (stat_i.len_bad) begin
          cmd_o.ins_fail = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d      = S_INS_LOOK;
        end
      end
      S_INS_LOOK: begin
        cmd_o.ins_look = 1'b1;
        if (stat_i.look_final) begin
          state_d = S_INS_REF;
        end else if (stat_i.look_hit) begin
          state_d = S_INS_RD;
        end else if (stat_i.look_fits) begin
          state_d = S_INS_ALLOC;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_INS_ALLOC: begin
        cmd_o.ins_alloc = 1'b1;
        if (stat_i.alloc_last) begin
          state_d = S_INS_REF;
        end
      end
      S_INS_REF: begin
        cmd_o.ins_ref = 1'b1;
        state_d       = S_INS_LOAD;
      end
      S_INS_LOAD: begin
        cmd_o.ins_load = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/htd_datapath.sv]
`timescale 1ns / 1ps

module htd_datapath #(
  parameter int unsigned NODE_COUNT = htd_pkg::HTD_NODE_COUNT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  htd_pkg::htd_cmd_t                   cmd_i,
  output htd_pkg::htd_stat_t                  stat_o,
  input  logic [htd_pkg::HTD_LEN_W-1:0]       code_length_i,
  input  logic [htd_pkg::HTD_CODE_W-1:0]      code_bits_i,
  input  logic [htd_pkg::HTD_SYM_W-1:0]       symbol_value_i,
  input  logic                                stream_bit_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [htd_pkg::HTD_STATUS_W-1:0]    status_o,
  output logic [htd_pkg::HTD_SYM_W-1:0]       symbol_out_o
);
  import htd_pkg::*;

  localparam int unsigned IdxW = $clog2(NODE_COUNT);
  localparam int unsigned CntW = $clog2(NODE_COUNT + 1);
  localparam int unsigned EntW = 2 * IdxW + HTD_SYM_W + 1;
  localparam logic [CntW-1:0] NodeTotal = CntW'(NODE_COUNT);

  typedef struct packed {
    logic [IdxW-1:0]      child1;
    logic [IdxW-1:0]      child0;
    logic [HTD_SYM_W-1:0] sym;
    logic                 has_sym;
  } node_t;

  // item and walk registers
  logic [HTD_LEN_W-1:0]  len_q;
  logic [HTD_CODE_W-1:0] code_q;
  logic [HTD_SYM_W-1:0]  sym_q;
  logic                  bit_q;
  logic [HTD_LEN_W-1:0]  rem_q, rem_d;
  logic [IdxW-1:0]       walk_q, walk_d;
  node_t                 cur_ent_q, cur_ent_d;

  // tree state
  node_t                 root_q, root_d;
  logic [CntW-1:0]       used_q, used_d;
  logic [IdxW-1:0]       cursor_q, cursor_d;
  logic                  rd_root_q;

  // result and output registers
  logic                  res_valid_q, res_valid_d;
  htd_status_e           res_status_q, res_status_d;
  logic [HTD_SYM_W-1:0]  res_sym_q, res_sym_d;
  logic                  out_valid_q;
  htd_status_e           out_status_q;
  logic [HTD_SYM_W-1:0]  out_sym_q;

  // node table port
  logic                  wr_go, rd_go, rd_is_root;
  logic                  ram_we, ram_re;
  logic [IdxW-1:0]       wr_addr, rd_addr;
  node_t                 wr_ent;
  logic [EntW-1:0]       ram_rdata;

  node_t                 rd_ent, cursor_ent;
  logic [HTD_LEN_W-1:0]  pos_look, pos_alloc;
  logic                  look_bit, alloc_bit;
  logic [IdxW-1:0]       look_child, dec_child, fresh;
  logic [CntW-1:0]       free_cnt;
  logic                  slot_free, res_move;

  htd_ram #(
    .WIDTH (EntW),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_ent),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign rd_ent     = rd_root_q ? root_q : node_t'(ram_rdata);
  assign cursor_ent = (cursor_q == '0) ? root_q : cur_ent_q;

  assign pos_look   = rem_q - HTD_LEN_W'(1);
  assign pos_alloc  = rem_q - HTD_LEN_W'(2);
  assign look_bit   = code_q[pos_look];
  assign alloc_bit  = code_q[pos_alloc];
  assign look_child = look_bit ? rd_ent.child1 : rd_ent.child0;
  assign dec_child  = bit_q ? cursor_ent.child1 : cursor_ent.child0;
  assign fresh      = used_q[IdxW-1:0];
  assign free_cnt   = NodeTotal - used_q;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign res_move   = res_valid_q && slot_free;

  always_comb begin
    stat_o            = '0;
    stat_o.len_bad    = (len_q == '0) || (32'(len_q) > HTD_MAX_CODE_LEN);
    stat_o.dec_miss   = (dec_child == '0);
    stat_o.look_final = (rem_q == '0);
    stat_o.look_hit   = (look_child != '0);
    stat_o.look_fits  = (CntW'(rem_q) <= free_cnt);
    stat_o.alloc_last = (rem_q == HTD_LEN_W'(1));
    stat_o.res_busy   = res_valid_q && !slot_free;
  end

  // table writes: symbol at an existing node, link to a new chain, new chain nodes
  always_comb begin
    wr_go   = 1'b0;
    wr_addr = walk_q;
    wr_ent  = rd_ent;
    if (cmd_i.ins_look) begin
      if (rem_q == '0) begin
        wr_go          = 1'b1;
        wr_ent.sym     = sym_q;
        wr_ent.has_sym = 1'b1;
      end else if ((look_child == '0) && stat_o.look_fits) begin
        wr_go = 1'b1;
        if (look_bit) begin
          wr_ent.child1 = fresh;
        end else begin
          wr_ent.child0 = fresh;
        end
      end
    end else if (cmd_i.ins_alloc) begin
      wr_go   = 1'b1;
      wr_addr = fresh;
      wr_ent  = '0;
      if (rem_q == HTD_LEN_W'(1)) begin
        wr_ent.sym     = sym_q;
        wr_ent.has_sym = 1'b1;
      end else if (alloc_bit) begin
        wr_ent.child1 = fresh + IdxW'(1);
      end else begin
        wr_ent.child0 = fresh + IdxW'(1);
      end
    end
  end

  always_comb begin
    root_d = root_q;
    ram_we = 1'b0;
    if (wr_go) begin
      if (wr_addr == '0) begin
        root_d = wr_ent;
      end else begin
        ram_we = 1'b1;
      end
    end
  end

  // table reads, the root lives in flops
  always_comb begin
    rd_go   = 1'b0;
    rd_addr = walk_q;
    if (cmd_i.ins_rd) begin
      rd_go = 1'b1;
    end else if (cmd_i.dec_step) begin
      rd_go   = (dec_child != '0);
      rd_addr = dec_child;
    end else if (cmd_i.ins_ref) begin
      rd_go   = 1'b1;
      rd_addr = cursor_q;
    end
    rd_is_root = rd_go && (rd_addr == '0);
    ram_re     = rd_go && !rd_is_root;
  end

  always_comb begin
    rem_d        = rem_q;
    walk_d       = walk_q;
    cur_ent_d    = cur_ent_q;
    used_d       = used_q;
    cursor_d     = cursor_q;
    res_valid_d  = res_move ? 1'b0 : res_valid_q;
    res_status_d = res_status_q;
    res_sym_d    = res_sym_q;

    if (cmd_i.take) begin
      rem_d  = code_length_i;
      walk_d = '0;
    end
    if (cmd_i.dec_step) begin
      if (dec_child == '0) begin
        res_valid_d  = 1'b1;
        res_status_d = ST_UNINDEXED;
        res_sym_d    = '0;
        cursor_d     = '0;
      end else begin
        walk_d = dec_child;
      end
    end
    if (cmd_i.dec_chk) begin
      res_valid_d = 1'b1;
      if (rd_ent.has_sym) begin
        res_status_d = ST_DECODED;
        res_sym_d    = rd_ent.sym;
        cursor_d     = '0;
      end else begin
        res_status_d = ST_CONSUMED;
        res_sym_d    = '0;
        cursor_d     = walk_q;
        cur_ent_d    = rd_ent;
      end
    end
    if (cmd_i.ins_look && (rem_q != '0)) begin
      if (look_child != '0) begin
        walk_d = look_child;
        rem_d  = pos_look;
      end else if (!stat_o.look_fits) begin
        res_valid_d  = 1'b1;
        res_status_d = ST_INSERT_FAIL;
        res_sym_d    = '0;
      end
    end
    if (cmd_i.ins_alloc) begin
      used_d = used_q + CntW'(1);
      rem_d  = pos_look;
    end
    if (cmd_i.ins_fail) begin
      res_valid_d  = 1'b1;
      res_status_d = ST_INSERT_FAIL;
      res_sym_d    = '0;
    end
    if (cmd_i.ins_load) begin
      cur_ent_d    = rd_ent;
      res_valid_d  = 1'b1;
      res_status_d = ST_INSERTED;
      res_sym_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q      <= '0;
      used_q      <= CntW'(1);
      cursor_q    <= '0;
      rd_root_q   <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      root_q      <= root_d;
      used_q      <= used_d;
      cursor_q    <= cursor_d;
      res_valid_q <= res_valid_d;
      if (rd_go) begin
        rd_root_q <= rd_is_root;
      end
      if (res_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      len_q  <= code_length_i;
      code_q <= code_bits_i;
      sym_q  <= symbol_value_i;
      bit_q  <= stream_bit_i;
    end
    rem_q        <= rem_d;
    walk_q       <= walk_d;
    cur_ent_q    <= cur_ent_d;
    res_status_q <= res_status_d;
    res_sym_q    <= res_sym_d;
    if (res_move) begin
      out_status_q <= res_status_q;
      out_sym_q    <= res_sym_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign symbol_out_o = out_sym_q;

endmodule

[hw/rtl/huffman_tree_bit_decoder.sv]
`timescale 1ns / 1ps

// Bit-serial binary code tree decoder. The tree lives in a node table of NODE_COUNT entries
// (two child links, a symbol and a symbol flag); the root is held in flops, all other nodes
// in a single-port-write, registered-read RAM. An insert beat (kind 0) walks from the root
// MSB first, adds any missing nodes in one chain and stores the symbol; it replies inserted
// or insert failed (zero length, length above the maximum, or not enough free nodes, in which
// case nothing changes). A decode beat (kind 1) moves the cursor by one stream bit and replies
// symbol decoded, bit consumed or unindexed code. Every beat gives exactly one result beat.
// Timing: a decode steps, then checks the child unless it is missing, set by one registered
// read of the node table per step; the cursor node is cached so only the child is read. An
// insert reads then inspects each existing tree level, allocates each new node in turn, then
// rereads the cursor node and reloads its cached copy. One item is in flight at a time, and a
// new beat is taken while the previous result still waits in the output register. After
// reset the table is usable at once: nodes other than the root are written when allocated.

module huffman_tree_bit_decoder #(
  parameter int unsigned NODE_COUNT = htd_pkg::HTD_NODE_COUNT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  htd_in_if.sink    in_i,
  htd_out_if.source out_o
);
  import htd_pkg::*;

  // command and status between the sequencer and the datapath
  htd_cmd_t  cmd;
  htd_stat_t stat;

  // sequencer: one-hot state machine, owns the input handshake
  htd_ctrl u_htd_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: node table, cursor, pool counter, result and output registers
  htd_datapath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_htd_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .code_length_i  (in_i.code_length),
    .code_bits_i    (in_i.code_bits),
    .symbol_value_i (in_i.symbol_value),
    .stream_bit_i   (in_i.stream_bit),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .status_o       (out_o.status),
    .symbol_out_o   (out_o.symbol_out)
  );

endmodule

[hw/rtl/htd_checker.sv]
`timescale 1ns / 1ps
`include "huffman_tree_bit_decoder_defines.svh"

module htd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [htd_pkg::HTD_STATUS_W-1:0] out_status_i,
  input logic [htd_pkg::HTD_SYM_W-1:0]    out_symbol_i
);
  import htd_pkg::*;

  logic       in_fire, out_fire;
  logic [1:0] pend_q, pend_d;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // beats accepted and not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (in_fire && !out_fire) begin
      pend_d = pend_q + 2'd1;
    end else if (out_fire && !in_fire) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `HTD_ASSERT(a_sym_zero, out_valid_i && (out_status_i != ST_DECODED) |-> out_symbol_i == '0, "symbol set on a non-decode result")
  `HTD_ASSERT(a_busy_after_accept, in_fire |=> !in_ready_i, "ready right after an accepted beat")
  `HTD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) && $stable(out_symbol_i), "stalled result changed")
  `HTD_ASSERT(a_no_phantom, out_valid_i |-> pend_q != 2'd0, "result without an accepted beat")
  `HTD_ASSERT(a_pend_bound, pend_q != 2'd3, "too many beats in flight")

endmodule

bind huffman_tree_bit_decoder htd_checker u_htd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_symbol_i (out_o.symbol_out)
);

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import htd_pkg::*;

  localparam int unsigned NODES        = HTD_NODE_COUNT;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_SHOWN    = 10;
  localparam int unsigned STALL_CYCLES = 300;

  // one input beat as the block sees it
  typedef struct packed {
    logic                  kind;
    logic [HTD_LEN_W-1:0]  code_length;
    logic [HTD_CODE_W-1:0] code_bits;
    logic [HTD_SYM_W-1:0]  symbol_value;
    logic                  stream_bit;
  } tree_beat_t;

  // one result beat
  typedef struct packed {
    htd_status_e          status;
    logic [HTD_SYM_W-1:0] symbol;
  } tree_reply_t;

  logic clk;
  logic rst_n;

  htd_in_if  in_if ();
  htd_out_if out_if ();

  huffman_tree_bit_decoder DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shadow copy of the code tree; link value 0 means no child
  int unsigned          zero_link   [NODES];
  int unsigned          one_link    [NODES];
  logic [HTD_SYM_W-1:0] leaf_symbol [NODES];
  bit                   leaf_flag   [NODES];
  int unsigned          nodes_taken;
  int unsigned          cursor;

  // results still owed by the block, oldest first
  tree_reply_t replies_due[$];

  // codes known to be in the tree, used to build well-formed bit streams
  int unsigned           book_len[$];
  logic [HTD_CODE_W-1:0] book_code[$];

  int unsigned status_tally [5];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned rx_hold_cycles;
  bit          gaps_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // next state of the shadow tree and the result for one accepted beat
  function automatic tree_reply_t tree_advance(tree_beat_t b);
    tree_reply_t r;
    int unsigned at;
    int unsigned nxt;
    int unsigned need;
    bit          off_tree;
    r.status = ST_INSERT_FAIL;
    r.symbol = '0;
    if (b.kind == KIND_DECODE) begin
      nxt = b.stream_bit ? one_link[cursor] : zero_link[cursor];
      if (nxt == 0) begin
        // missing branch: error and back to the root
        r.status = ST_UNINDEXED;
        cursor   = 0;
      end else if (leaf_flag[nxt]) begin
        r.status = ST_DECODED;
        r.symbol = leaf_symbol[nxt];
        cursor   = 0;
      end else begin
        r.status = ST_CONSUMED;
        cursor   = nxt;
      end
    end else if (b.code_length != 0 && b.code_length <= HTD_MAX_CODE_LEN) begin
      // first pass counts the nodes the code would add
      at       = 0;
      need     = 0;
      off_tree = 1'b0;
      for (int i = b.code_length - 1; i >= 0; i--) begin
        if (off_tree) begin
          need++;
        end else begin
          nxt = b.code_bits[i] ? one_link[at] : zero_link[at];
          if (nxt == 0) begin
            off_tree = 1'b1;
            need++;
          end else begin
            at = nxt;
          end
        end
      end
      // all or nothing: a code that does not fit leaves the tree alone
      if (need <= NODES - nodes_taken) begin
        at = 0;
        for (int i = b.code_length - 1; i >= 0; i--) begin
          nxt = b.code_bits[i] ? one_link[at] : zero_link[at];
          if (nxt == 0) begin
            nxt              = nodes_taken;
            nodes_taken      = nodes_taken + 1;
            zero_link[nxt]   = 0;
            one_link[nxt]    = 0;
            leaf_flag[nxt]   = 1'b0;
            leaf_symbol[nxt] = '0;
            if (b.code_bits[i]) begin
              one_link[at] = nxt;
            end else begin
              zero_link[at] = nxt;
            end
          end
          at = nxt;
        end
        // the cursor is not touched, so a decode in progress carries on
        leaf_symbol[at] = b.symbol_value;
        leaf_flag[at]   = 1'b1;
        r.status        = ST_INSERTED;
      end
    end
    return r;
  endfunction

  function automatic void log_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endfunction

  // offer one beat after a random gap, hold it until taken, then log what it owes
  task automatic send_beat(tree_beat_t b);
    int unsigned idle;
    tree_reply_t r;
    idle = gaps_on ? $urandom_range(0, 8) : 0;
    if (idle != 0) begin
      in_if.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= b.kind;
    in_if.code_length  <= b.code_length;
    in_if.code_bits    <= b.code_bits;
    in_if.symbol_value <= b.symbol_value;
    in_if.stream_bit   <= b.stream_bit;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    r = tree_advance(b);
    replies_due.push_back(r);
    status_tally[r.status]++;
    if (b.kind == KIND_INSERT && r.status == ST_INSERTED) begin
      book_len.push_back(32'(b.code_length));
      book_code.push_back(b.code_bits);
    end
  endtask

  // fields that the beat's kind ignores carry random junk
  task automatic send_decode(bit stream_bit);
    tree_beat_t b;
    b            = tree_beat_t'($urandom);
    b.kind       = KIND_DECODE;
    b.stream_bit = stream_bit;
    send_beat(b);
  endtask

  task automatic send_insert(int unsigned len, int unsigned code, int unsigned sym);
    tree_beat_t b;
    b              = tree_beat_t'($urandom);
    b.kind         = KIND_INSERT;
    b.code_length  = len[HTD_LEN_W-1:0];
    b.code_bits    = code[HTD_CODE_W-1:0];
    b.symbol_value = sym[HTD_SYM_W-1:0];
    send_beat(b);
  endtask

  // stream the leading nbits of a known code, msb first
  task automatic send_code_prefix(int idx, int nbits);
    int len;
    len = book_len[idx];
    for (int i = len - 1; i >= len - nbits; i--) begin
      send_decode(book_code[idx][i]);
    end
  endtask

  task automatic test_directed();
    gaps_on = 1'b1;
    // empty tree: neither branch exists at the root
    send_decode(1'b0);
    send_decode(1'b1);
    // zero-length code is refused
    send_insert(0, 'h7fff, 'h005);
    // code 11 with the largest symbol
    send_insert(2, 'h0003, 'h1ff);
    send_decode(1'b1);
    send_decode(1'b1);
    // longest codes: all zeros with symbol zero, all ones passing the symbol node at 11
    send_insert(15, 'h0000, 'h000);
    send_insert(15, 'h7fff, 'h0aa);
    // three steps down the zero chain, then label the node the cursor sits on
    send_decode(1'b0);
    send_decode(1'b0);
    send_decode(1'b0);
    send_insert(3, 'h0000, 'h155);
    // cursor kept by the insert: one level deeper, then a missing branch
    send_decode(1'b0);
    send_decode(1'b1);
    // the three-bit zero code now stops early on the new symbol
    send_decode(1'b0);
    send_decode(1'b0);
    send_decode(1'b0);
    // overwrite code 11; unused upper code bits are junk
    send_insert(2, 'h5553, 'h0f0);
    send_decode(1'b1);
    send_decode(1'b1);
  endtask

  // rounds of a few new codes followed by streams of known codes with some noise
  task automatic test_stream_rounds();
    int unsigned len;
    int          idx;
    int          cut;
    for (int round = 0; round < 11; round++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (8) begin
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 7) : $urandom_range(8, 12);
        send_insert(len, $urandom, $urandom);
      end
      repeat (25) begin
        idx = $urandom_range(0, book_len.size() - 1);
        case ($urandom_range(0, 9))
          0: begin
            // stray bit, shifts the stream off its code boundaries
            send_decode(1'($urandom_range(0, 1)));
          end
          1: begin
            // insert in the middle of a code, sometimes a zero-length one
            cut = $urandom_range(0, book_len[idx]);
            send_code_prefix(idx, cut);
            send_insert($urandom_range(0, 6), $urandom, $urandom);
          end
          2: begin
            // broken code: only its first part arrives
            send_code_prefix(idx, $urandom_range(0, book_len[idx]));
          end
          default: begin
            send_code_prefix(idx, book_len[idx]);
          end
        endcase
      end
    end
  endtask

  // receiver goes quiet while the sender keeps offering, so the input must stall
  task automatic test_output_stall();
    gaps_on        = 1'b0;
    rx_hold_cycles = STALL_CYCLES;
    repeat (10) send_code_prefix($urandom_range(0, book_len.size() - 1), 1);
    repeat (10) begin
      send_code_prefix($urandom_range(0, book_len.size() - 1), 1);
      send_decode(1'($urandom_range(0, 1)));
      send_decode(1'($urandom_range(0, 1)));
      send_decode(1'($urandom_range(0, 1)));
    end
  endtask

  // fill the node pool, probing the exact fit and one node too many
  task automatic test_pool_exhaustion();
    int unsigned spare;
    int unsigned tries;
    int          idx;
    gaps_on = 1'b1;
    tries   = 0;
    spare   = NODES - nodes_taken;
    while (spare != 0 && tries < 200) begin
      if (spare >= HTD_MAX_CODE_LEN) begin
        // long random codes branch off early and eat many nodes
        send_insert(15, $urandom, $urandom);
      end else begin
        // zero chain then a one at depth 15-spare: needs spare+1 nodes, then spare
        send_insert(15, (1 << spare) | ($urandom & ((1 << spare) - 1)), $urandom);
        send_insert(15, (1 << (spare - 1)) | ($urandom & ((1 << (spare - 1)) - 1)),
                    $urandom);
      end
      tries++;
      spare = NODES - nodes_taken;
    end
    // pool full: new branches are refused, existing codes can still be relabeled
    repeat (6) begin
      send_insert($urandom_range(1, 15), $urandom, $urandom);
      idx = $urandom_range(0, book_len.size() - 1);
      send_insert(book_len[idx], book_code[idx], $urandom);
    end
    repeat (30) begin
      idx = $urandom_range(0, book_len.size() - 1);
      send_code_prefix(idx, book_len[idx]);
    end
  endtask

  // result side: random ready gaps, plus one long hold-off on request
  initial begin : result_sink
    int unsigned pause;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_cycles != 0) begin
        pause          = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_if.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      pause = gaps_on ? $urandom_range(0, 8) : 0;
      if (pause != 0) begin
        out_if.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  // compare every result beat against the oldest owed result
  always @(posedge clk) begin : reply_check
    tree_reply_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (replies_due.size() == 0) begin
        log_mismatch($sformatf("status %0d symbol 0x%0h with nothing expected",
                               out_if.status, out_if.symbol_out));
      end else begin
        want = replies_due.pop_front();
        if (out_if.status !== want.status || out_if.symbol_out !== want.symbol) begin
          log_mismatch($sformatf("expected %s symbol 0x%0h, got status %0d symbol 0x%0h",
                                 want.status.name(), want.symbol,
                                 out_if.status, out_if.symbol_out));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, replies_due.size());
      $display("huffman_tree_bit_decoder regression: fail");
      $finish;
    end
  end

  initial begin : run
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.kind         <= KIND_INSERT;
    in_if.code_length  <= '0;
    in_if.code_bits    <= '0;
    in_if.symbol_value <= '0;
    in_if.stream_bit   <= 1'b0;
    for (int n = 0; n < NODES; n++) begin
      zero_link[n]   = 0;
      one_link[n]    = 0;
      leaf_symbol[n] = '0;
      leaf_flag[n]   = 1'b0;
    end
    for (int s = 0; s < 5; s++) status_tally[s] = 0;
    nodes_taken    = 1;
    cursor         = 0;
    mismatches     = 0;
    cycle_count    = 0;
    rx_hold_cycles = 0;
    gaps_on        = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_stream_rounds();
    test_output_stall();
    test_pool_exhaustion();

    in_if.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    // catch any extra beat the block might still push out
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("decode beats: %0d symbols, %0d bits consumed, %0d unindexed codes",
             status_tally[ST_DECODED], status_tally[ST_CONSUMED],
             status_tally[ST_UNINDEXED]);
    $display("insert beats: %0d stored, %0d refused; tree holds %0d of %0d nodes",
             status_tally[ST_INSERTED], status_tally[ST_INSERT_FAIL], nodes_taken, NODES);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("huffman_tree_bit_decoder regression: pass");
    end else begin
      $display("huffman_tree_bit_decoder regression: fail");
    end
    $finish;
  end

endmodule
